// ===== sv/lru_fifo_page_replacement_defines.svh =====
// Assertion macros shared by the page replacement RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef LRU_FIFO_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_FIFO_PAGE_REPLACEMENT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define LFPR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define LFPR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LFPR_ASSERT_IMP(label, ante, cons, msg)
`define LFPR_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== sv/lfpr_pkg.sv =====
`timescale 1ns / 1ps

package lfpr_pkg;

    localparam int PAGE_W  = 16;
    localparam int INDEX_W = 2;
    localparam int COUNT_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Request policy codes.
    localparam logic POLICY_LRU  = 1'b0;
    localparam logic POLICY_FIFO = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [PAGE_W-1:0] page_number;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [INDEX_W-1:0] frame_index;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [COUNT_W-1:0] fault_total;
    } rsp_t;

endpackage

// ===== sv/lfpr_req_if.sv =====
`timescale 1ns / 1ps

interface lfpr_req_if;
    import lfpr_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/lfpr_rsp_if.sv =====
`timescale 1ns / 1ps

interface lfpr_rsp_if;
    import lfpr_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/lru_fifo_page_replacement.sv =====
`timescale 1ns / 1ps
`include "lru_fifo_page_replacement_defines.svh"
// Page replacement over a small fully associative frame set.
// Channel req carries one page request per item: a policy bit (LRU or FIFO)
// and a page number, of which the low PAGE_BITS bits (at most PAGE_W) take part. Channel rsp
// returns one result item per request: hit flag, frame index, the evicted
// page if a valid page was replaced, and the saturating fault total.
// Both channels use valid/ready; an item moves when both are high.
// A request is registered on acceptance; when it advances, the tag compare,
// victim choice and rank update run in one pass and the result register is
// loaded, so a result is offered once its request leaves the input register.
// While rsp is ready one item per cycle is sustained; the frame state is written
// in the same edge that loads the result, so the next request sees it at once.
// Reset leaves all frames empty and the fault count at zero; requests are
// taken from the first cycle after reset with no clearing pass.
// When rsp stalls the result is held, one more request waits in the input
// register, and req.ready then drops until the result is taken.
module lru_fifo_page_replacement #(
    parameter int NUM_FRAMES = 4,
    parameter int PAGE_BITS  = 16
) (
    input logic      clk,
    input logic      rst_n,
    lfpr_req_if.sink   req,
    lfpr_rsp_if.source rsp
);
    import lfpr_pkg::*;

    localparam int FW = $clog2(NUM_FRAMES);
    localparam int SW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam logic [FW-1:0] LAST_FRAME = FW'(NUM_FRAMES - 1);

    // Input stage
    logic    in_valid_reg, in_valid_next;
    req_t    in_req_reg;

    // Output stage
    logic    out_valid_reg, out_valid_next;
    rsp_t    out_rsp_reg;

    // Frame state
    logic [SW-1:0] frame_page_reg [NUM_FRAMES];
    logic [SW-1:0] frame_page_next [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] frame_valid_reg, frame_valid_next;
    logic [FW-1:0] age_rank_reg [NUM_FRAMES];
    logic [FW-1:0] age_rank_next [NUM_FRAMES];
    logic [FW-1:0] fifo_pointer_reg, fifo_pointer_next;
    logic [COUNT_W-1:0] fault_count_reg, fault_count_next;

    logic                  advance;
    logic [SW-1:0]         page_c;
    logic                  fifo_c;
    logic [NUM_FRAMES-1:0] match_c;
    logic [NUM_FRAMES-1:0] top_c;
    logic                  hit_c;
    logic [FW-1:0]         hit_idx_c;
    logic [FW-1:0]         lru_idx_c;
    logic [FW-1:0]         idx_c;
    logic [FW-1:0]         used_rank_c;
    logic                  ev_valid_c;
    logic [SW-1:0]         ev_page_c;
    rsp_t                  rsp_c;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_rsp_reg;

    assign page_c = in_req_reg.page_number[SW-1:0];
    assign fifo_c = (in_req_reg.req_type == POLICY_FIFO);

    always_comb
    begin
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            match_c[i] = frame_valid_reg[i] && (frame_page_reg[i] == page_c);
            top_c[i]   = (age_rank_reg[i] == LAST_FRAME);
        end
    end

    // Lowest matching index wins; the LRU victim is the lowest index at top rank,
    // which always exists because ranks below the top are held by distinct frames.
    always_comb
    begin
        hit_idx_c = '0;
        lru_idx_c = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--)
        begin
            if (match_c[i])
            begin
                hit_idx_c = FW'(i);
            end
            if (top_c[i])
            begin
                lru_idx_c = FW'(i);
            end
        end
    end

    assign hit_c       = |match_c;
    assign idx_c       = hit_c ? hit_idx_c : (fifo_c ? fifo_pointer_reg : lru_idx_c);
    assign used_rank_c = age_rank_reg[idx_c];
    assign ev_valid_c  = !hit_c && frame_valid_reg[idx_c];
    assign ev_page_c   = ev_valid_c ? frame_page_reg[idx_c] : '0;

    always_comb
    begin
        rsp_c.hit           = hit_c;
        rsp_c.frame_index   = INDEX_W'(idx_c);
        rsp_c.evicted_valid = ev_valid_c;
        rsp_c.evicted_page  = PAGE_W'(ev_page_c);
        rsp_c.fault_total   = fault_count_next;
    end

    always_comb
    begin
        frame_page_next   = frame_page_reg;
        frame_valid_next  = frame_valid_reg;
        age_rank_next     = age_rank_reg;
        fifo_pointer_next = fifo_pointer_reg;
        fault_count_next  = fault_count_reg;

        if (advance)
        begin
            if (!fifo_c)
            begin
                for (int i = 0; i < NUM_FRAMES; i++)
                begin
                    if (FW'(i) == idx_c)
                    begin
                        age_rank_next[i] = '0;
                    end
                    else if (age_rank_reg[i] < used_rank_c)
                    begin
                        age_rank_next[i] = age_rank_reg[i] + 1'b1;
                    end
                end
            end
            if (!hit_c)
            begin
                frame_page_next[idx_c]  = page_c;
                frame_valid_next[idx_c] = 1'b1;
                if (fault_count_reg != COUNT_MAX)
                begin
                    fault_count_next = fault_count_reg + 1'b1;
                end
                if (fifo_c)
                begin
                    fifo_pointer_next = (fifo_pointer_reg == LAST_FRAME) ? '0
                                        : fifo_pointer_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        if (req.valid && req.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            frame_valid_reg  <= '0;
            fifo_pointer_reg <= '0;
            fault_count_reg  <= '0;
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                age_rank_reg[i] <= LAST_FRAME;
            end
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            out_valid_reg    <= out_valid_next;
            frame_valid_reg  <= frame_valid_next;
            fifo_pointer_reg <= fifo_pointer_next;
            fault_count_reg  <= fault_count_next;
            age_rank_reg     <= age_rank_next;
        end
    end

    // Frame pages are only read behind their valid bits.
    always_ff @(posedge clk)
    begin
        frame_page_reg <= frame_page_next;
        if (req.valid && req.ready)
        begin
            in_req_reg <= req.data;
        end
        if (advance)
        begin
            out_rsp_reg <= rsp_c;
        end
    end

    `LFPR_ASSERT_IMP(a_single_match, in_valid_reg, $onehot0(match_c), "page resident twice")
    `LFPR_ASSERT_IMP(a_top_rank, 1'b1, |top_c, "no frame at top rank")
    `LFPR_ASSERT_NXT(a_result_loaded, advance, out_valid_reg, "result not offered")
    `LFPR_ASSERT_NXT(a_fault_counted, advance && !hit_c, fault_count_reg != '0,
                     "fault not counted")

endmodule
